/* hw/rtl/lpc_pkg.sv */
package lpc_pkg;

  // Field widths of the request and result transactions.
  localparam int PAGE_W = 10;
  localparam int OCC_W  = 5;
  localparam int CAP_W  = 5;

  // Page numbers wrap at this size.
  localparam int NUM_PAGES = 1024;

  // Value of the capacity register after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [PAGE_W-1:0] page_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic  update;
    page_t page;
  } lpc_cmd_t;

  // What one cell hands to the next one down the recency stack.
  typedef struct packed {
    page_t entry;
    logic  seen;
  } lpc_link_t;

endpackage

/* hw/rtl/lpc_req_if.sv */
interface lpc_req_if import lpc_pkg::*; ();
  logic  valid;
  logic  ready;
  page_t page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

/* hw/rtl/lpc_rsp_if.sv */
interface lpc_rsp_if import lpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted_valid;
  page_t            evicted_page;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output hit, output evicted_valid, output evicted_page,
                  output occupancy, input ready);
  modport sink (input valid, input hit, input evicted_valid, input evicted_page,
                input occupancy, output ready);
endinterface

/* hw/rtl/lru_page_cache_core.sv */
// LRU page cache: each request transaction names a page, and one result transaction comes back
// per request with the hit flag, the evicted page (zero when nothing was evicted) and the number
// of pages held afterward. The recency stack is a row of MAX_CAPACITY identical cells, the most
// recent page in cell 0; every cell compares its page with the request in parallel and, on an
// update, the cells from the top down to the hit position (or all of them on a miss) take the
// page of their upper neighbor while cell 0 takes the requested page. The result of an accepted
// request is registered, so the result appears in the cycle after acceptance, and
// the block takes one request per cycle as long as results are taken; the longest path is the
// match ripple that runs through the cell row. The capacity register (reset 16) may be written
// only while no transaction is in flight; zero acts as one and values above MAX_CAPACITY act as
// MAX_CAPACITY. Lowering it below the occupancy makes each miss evict one page and add one, so
// the occupancy stays put. No clearing pass is needed after reset: the fill count alone tells
// which cells hold pages.
module lru_page_cache_core import lpc_pkg::*; #(
  parameter int MAX_CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  lpc_req_if.sink          in_ch,
  lpc_rsp_if.source        out_ch
);

  localparam int CNT_W = $clog2(MAX_CAPACITY + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] held_r;
  logic [CNT_W-1:0] held_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             hit_r;
  logic             evicted_valid_r;
  page_t            evicted_page_r;
  logic [OCC_W-1:0] occupancy_r;

  logic             accept;
  page_t            page;
  lpc_cmd_t         cmd;
  lpc_link_t        link [MAX_CAPACITY+1];
  page_t            tail_pages [MAX_CAPACITY];
  page_t            tail_page;
  logic             hit;
  logic             evict;
  logic [CMP_W-1:0] eff_cap;

  // A new request is taken whenever the result register is empty or is being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign page        = page_t'(in_ch.page_number % NUM_PAGES);

  assign cmd.update = accept;
  assign cmd.page   = page;

  // Cell 0 receives the requested page; no match lies above it.
  assign link[0].entry = page;
  assign link[0].seen  = 1'b0;

  for (genvar i = 0; i < MAX_CAPACITY; i++) begin : g_cell
    lpc_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .held      (held_r),
      .link_in   (link[i]),
      .link_out  (link[i+1]),
      .tail_page (tail_pages[i])
    );
  end

  // At most one cell flags itself as the least recent entry, so an OR picks its page.
  always_comb begin
    tail_page = '0;
    for (int i = 0; i < MAX_CAPACITY; i++) begin
      tail_page = tail_page | tail_pages[i];
    end
  end

  // The capacity in force: zero counts as one, and it never exceeds the number of cells.
  always_comb begin
    if (capacity_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity_r) > CMP_W'(MAX_CAPACITY)) begin
      eff_cap = CMP_W'(MAX_CAPACITY);
    end else begin
      eff_cap = CMP_W'(capacity_r);
    end
  end

  assign hit   = link[MAX_CAPACITY].seen;
  assign evict = !hit && (CMP_W'(held_r) >= eff_cap);

  // A miss without eviction adds a page; a hit or an eviction leaves the count alone.
  always_comb begin
    held_nxt = held_r;
    if (accept && !hit && !evict) begin
      held_nxt = held_r + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r           <= hit;
      evicted_valid_r <= evict;
      evicted_page_r  <= evict ? tail_page : '0;
      occupancy_r     <= OCC_W'(held_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = hit_r;
  assign out_ch.evicted_valid = evicted_valid_r;
  assign out_ch.evicted_page  = evicted_page_r;
  assign out_ch.occupancy     = occupancy_r;

  // The fill count never runs past the number of cells.
  a_held_bound : assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(MAX_CAPACITY) >= held_r)
    else $error("held count exceeds the cell count");

  // A hit never evicts, and a transaction without eviction reports page zero.
  a_evict_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!(hit_r && evicted_valid_r) &&
                     (evicted_valid_r || (evicted_page_r == '0))))
    else $error("inconsistent eviction fields");

  // A hit or an eviction leaves the fill count where it was.
  a_held_stable : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (hit || evict)) |=> (held_r == $past(held_r)))
    else $error("fill count moved on a hit or eviction");

  // A miss without eviction grows the fill count by exactly one.
  a_held_grow : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !hit && !evict) |=> (held_r == $past(held_r) + CNT_W'(1)))
    else $error("fill count did not grow on a plain miss");

  // A result that was not taken is still offered in the next cycle.
  a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(occupancy_r)))
    else $error("pending result was lost");

endmodule

/* hw/rtl/lpc_cell.sv */
module lpc_cell import lpc_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  lpc_cmd_t         cmd,
  input  logic [CNT_W-1:0] held,
  input  lpc_link_t        link_in,
  output lpc_link_t        link_out,
  output page_t            tail_page
);

  page_t entry_r;
  page_t entry_nxt;
  logic  occupied;
  logic  match;
  logic  is_tail;

  // Only entries below the fill count hold pages; the contents of the rest never affect a match.
  assign occupied = CNT_W'(IDX) < held;
  assign match    = occupied && (entry_r == cmd.page);
  assign is_tail  = CNT_W'(IDX + 1) == held;

  assign link_out.entry = entry_r;
  assign link_out.seen  = link_in.seen | match;
  assign tail_page      = is_tail ? entry_r : '0;

  // A cell at or above the hit position takes its neighbor's page.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.update && !link_in.seen) begin
      entry_nxt = link_in.entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
